// File: rtl/speech_segment_detector_defines.svh
// ----------------------------------------------------------------------------
// Speech segment detector assertion macros
// Shared concurrent assertion forms for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef SPEECH_SEGMENT_DETECTOR_DEFINES_SVH
`define SPEECH_SEGMENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Speech segment detector package
// Item types, register codes and fixed constants of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int SMP_W     = 32;
  localparam int PROB_W    = 16;
  localparam int MS_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Milliseconds to samples: ms * (rate mod 1000) is below 2^26, and the
  // division of that by 1000 is a multiply by ceil(2^36 / 1000).
  localparam int DPROD_W   = 26;
  localparam int RECIP_W   = 27;
  localparam int DIV_SHIFT = 36;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
  localparam int MS_PER_S  = 1000;

  localparam logic [PROB_W-1:0] OFF_DELTA = 16'd9830;
  localparam logic [PROB_W-1:0] OFF_FLOOR = 16'd655;

  localparam logic [PROB_W-1:0] RST_ON_THR = 16'd32768;
  localparam int RST_MIN_SPEECH_MS  = 250;
  localparam int RST_MIN_SILENCE_MS = 100;
  localparam int RST_PAD_MS         = 30;

  typedef logic [SMP_W-1:0] smp_t;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_THR      = 2'd0,
    REG_MIN_SPEECH  = 2'd1,
    REG_MIN_SILENCE = 2'd2,
    REG_PAD         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e              command;
    logic [PROB_W-1:0] probability;
    smp_t              audio_length;
  } in_item_t;

  typedef struct packed {
    smp_t segment_start;
    smp_t segment_end;
    logic final_segment;
  } out_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] on_thr;
    logic [PROB_W-1:0] off_thr;
    smp_t              min_speech;
    smp_t              min_silence;
    smp_t              pad;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      count;
    out_item_t [1:0] item;
  } res_t;

  function automatic logic [PROB_W-1:0] off_threshold(input logic [PROB_W-1:0] on_thr);
    logic [PROB_W:0] limit;
    limit = {1'b0, OFF_FLOOR} + {1'b0, OFF_DELTA};
    if ({1'b0, on_thr} > limit) begin
      return on_thr - OFF_DELTA;
    end
    return OFF_FLOOR;
  endfunction

endpackage

// File: rtl/ssd_cfg.sv
// ----------------------------------------------------------------------------
// Speech segment detector configuration
// Holds the thresholds and converts millisecond settings to sample counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_cfg #(
  parameter int SAMPLE_RATE_HZ = 16000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssd_pkg::CFG_W-1:0]      cfg_wdata_i,
  output ssd_pkg::cfg_t                  cfg_o
);
  import ssd_pkg::*;

  localparam int RateK = SAMPLE_RATE_HZ / MS_PER_S;
  localparam int RateR = SAMPLE_RATE_HZ % MS_PER_S;
  localparam smp_t SpeechRst  = SMP_W'(SAMPLE_RATE_HZ * RST_MIN_SPEECH_MS / MS_PER_S);
  localparam smp_t SilenceRst = SMP_W'(SAMPLE_RATE_HZ * RST_MIN_SILENCE_MS / MS_PER_S);
  localparam smp_t PadRst     = SMP_W'(SAMPLE_RATE_HZ * RST_PAD_MS / MS_PER_S);
  localparam int FullW = DPROD_W + RECIP_W;

  logic [PROB_W-1:0]  on_thr_q, off_thr_q;
  smp_t               speech_q, silence_q, pad_q;
  logic               pend_q;
  cfg_idx_e           pend_idx_q;
  smp_t               cprod_q;
  logic [DPROD_W-1:0] dprod_q;
  logic [FullW-1:0]   full;
  smp_t               samples;

  assign full    = FullW'(dprod_q) * FullW'(DIV_RECIP);
  assign samples = cprod_q + SMP_W'(full[DIV_SHIFT +: MS_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q  <= RST_ON_THR;
      off_thr_q <= off_threshold(RST_ON_THR);
      speech_q  <= SpeechRst;
      silence_q <= SilenceRst;
      pad_q     <= PadRst;
      pend_q    <= 1'b0;
    end else begin
      pend_q <= cfg_we_i && (cfg_idx_e'(cfg_index_i) != REG_ON_THR);
      if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == REG_ON_THR)) begin
        on_thr_q  <= cfg_wdata_i;
        off_thr_q <= off_threshold(cfg_wdata_i);
      end
      if (pend_q) begin
        case (pend_idx_q)
          REG_MIN_SPEECH:  speech_q  <= samples;
          REG_MIN_SILENCE: silence_q <= samples;
          REG_PAD:         pad_q     <= samples;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      pend_idx_q <= cfg_idx_e'(cfg_index_i);
      cprod_q    <= SMP_W'(cfg_wdata_i) * SMP_W'(RateK);
      dprod_q    <= DPROD_W'(cfg_wdata_i) * DPROD_W'(RateR);
    end
  end

  assign cfg_o.on_thr      = on_thr_q;
  assign cfg_o.off_thr     = off_thr_q;
  assign cfg_o.min_speech  = speech_q;
  assign cfg_o.min_silence = silence_q;
  assign cfg_o.pad         = pad_q;

endmodule

// File: rtl/ssd_core.sv
// ----------------------------------------------------------------------------
// Speech segment detector core
// Hysteresis, segment closing, length test, padding and flush of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_core #(
  parameter int FRAME_SAMPLES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              proc_i,
  input  ssd_pkg::in_item_t item_i,
  input  ssd_pkg::cfg_t     cfg_i,
  output ssd_pkg::res_t     res_o
);
  import ssd_pkg::*;

  localparam smp_t FrameStep = SMP_W'(FRAME_SAMPLES);

  logic in_speech_q, in_speech_d;
  smp_t open_q, open_d;
  smp_t sil_q, sil_d;
  smp_t pos_q, pos_d;
  logic held_valid_q, held_valid_d;
  smp_t held_start_q, held_start_d;
  smp_t held_end_q, held_end_d;

  logic       speech, silence, close_ok;
  smp_t       sil_tmp, sil_pos;
  logic       offer_en, keep, small_gap, taken;
  smp_t       off_end, sat_start, gap, half, new_start;
  out_item_t  offer_item, last_item;
  smp_t       fl_start, fl_end;
  logic       fl_valid;
  logic [SMP_W:0] fl_sum;

  always_comb begin
    speech   = item_i.probability >= cfg_i.on_thr;
    silence  = item_i.probability < cfg_i.off_thr;
    sil_tmp  = speech ? '0 : sil_q;
    sil_pos  = (sil_tmp == '0) ? pos_q : sil_tmp;
    close_ok = (pos_q - sil_pos) >= cfg_i.min_silence;

    off_end   = (item_i.command == CMD_FLUSH) ? pos_q : sil_pos;
    keep      = (off_end - open_q) > cfg_i.min_speech;
    sat_start = (open_q >= cfg_i.pad) ? open_q - cfg_i.pad : '0;
    gap       = open_q - held_end_q;
    half      = gap >> 1;
    small_gap = {1'b0, gap} < {cfg_i.pad, 1'b0};
    new_start = (held_valid_q && small_gap) ? open_q - half : sat_start;
    offer_item.segment_start = held_start_q;
    offer_item.segment_end   = small_gap ? held_end_q + half : held_end_q + cfg_i.pad;
    offer_item.final_segment = 1'b0;

    offer_en = 1'b0;
    if (item_i.command == CMD_FLUSH) begin
      offer_en = in_speech_q;
    end else if (!(speech && !in_speech_q) && silence && in_speech_q && close_ok) begin
      offer_en = 1'b1;
    end
    taken = offer_en && keep;

    fl_valid = held_valid_q || taken;
    fl_start = taken ? new_start : held_start_q;
    fl_end   = taken ? off_end : held_end_q;
    fl_sum   = {1'b0, fl_end} + {1'b0, cfg_i.pad};
    last_item.segment_start = fl_start;
    last_item.segment_end   = (fl_sum > {1'b0, item_i.audio_length}) ?
                              item_i.audio_length : fl_sum[SMP_W-1:0];
    last_item.final_segment = 1'b1;

    in_speech_d  = in_speech_q;
    open_d       = open_q;
    sil_d        = sil_q;
    pos_d        = pos_q;
    held_valid_d = held_valid_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    res_o        = '0;

    if (proc_i) begin
      case (item_i.command)
        CMD_FRAME: begin
          pos_d = pos_q + FrameStep;
          sil_d = sil_tmp;
          if (speech && !in_speech_q) begin
            in_speech_d = 1'b1;
            open_d      = pos_q;
          end else if (silence && in_speech_q) begin
            sil_d = sil_pos;
            if (close_ok) begin
              in_speech_d = 1'b0;
              open_d      = '0;
              sil_d       = '0;
              if (taken) begin
                held_valid_d = 1'b1;
                held_start_d = new_start;
                held_end_d   = off_end;
                if (held_valid_q) begin
                  res_o.count   = 2'd1;
                  res_o.item[0] = offer_item;
                end
              end
            end
          end
        end
        CMD_FLUSH: begin
          if (taken && held_valid_q) begin
            res_o.item[0] = offer_item;
            res_o.item[1] = last_item;
            res_o.count   = 2'd2;
          end else if (fl_valid) begin
            res_o.item[0] = last_item;
            res_o.count   = 2'd1;
          end
          in_speech_d  = 1'b0;
          open_d       = '0;
          sil_d        = '0;
          pos_d        = '0;
          held_valid_d = 1'b0;
          held_start_d = '0;
          held_end_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_speech_q  <= 1'b0;
      open_q       <= '0;
      sil_q        <= '0;
      pos_q        <= '0;
      held_valid_q <= 1'b0;
      held_start_q <= '0;
      held_end_q   <= '0;
    end else begin
      in_speech_q  <= in_speech_d;
      open_q       <= open_d;
      sil_q        <= sil_d;
      pos_q        <= pos_d;
      held_valid_q <= held_valid_d;
      held_start_q <= held_start_d;
      held_end_q   <= held_end_d;
    end
  end

endmodule

// File: rtl/ssd_outq.sv
// ----------------------------------------------------------------------------
// Speech segment detector result queue
// Two-entry result buffer between the core and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssd_pkg::res_t      res_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssd_pkg::out_item_t out_data_o
);
  import ssd_pkg::*;

  out_item_t [1:0] q_q, q_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = q_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // The core may only push when the queue drains to empty in this cycle.
  assign room_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    q_d   = q_q;
    cnt_d = cnt_q - {1'b0, pop};
    if (pop) begin
      q_d[0] = q_q[1];
    end
    if (push_i) begin
      q_d   = res_i.item;
      cnt_d = res_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

// File: rtl/speech_segment_detector.sv
// ----------------------------------------------------------------------------
// Speech segment detector: per-frame probabilities in, padded segments out.
// Each item is registered in the input stage, and its results are registered in the
// result queue. Throughput: one item per cycle while results are taken; an item
// waits while a second result is still queued, as after a flush with two results.
// Reset clears all state and loads defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speech_segment_detector_defines.svh"

module speech_segment_detector #(
  parameter int FRAME_SAMPLES  = 512,
  parameter int SAMPLE_RATE_HZ = 16000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ssd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ssd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ssd_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import ssd_pkg::*;

  logic     in_v_q;
  in_item_t in_q;
  logic     room, proc, accept;
  cfg_t     cfg;
  res_t     res;

  assign proc       = in_v_q && room;
  assign in_ready_o = !in_v_q || proc;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept) begin
      in_v_q <= 1'b1;
    end else if (proc) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  ssd_cfg #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ssd_core #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .proc_i(proc),
    .item_i(in_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  ssd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (proc),
    .res_i      (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `SSD_ASSERT(a_frame_single, clk_i, rst_ni,
              proc && (in_q.command == CMD_FRAME),
              (res.count <= 2'd1) && !res.item[0].final_segment,
              "frame item gave more than one or a final result")
  `SSD_ASSERT(a_flush_order, clk_i, rst_ni,
              proc && (res.count == 2'd2),
              (in_q.command == CMD_FLUSH) && res.item[1].final_segment
                && !res.item[0].final_segment,
              "two results not ending in the final one")
  `SSD_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni,
                   in_v_q && !proc,
                   in_v_q && $stable(in_q),
                   "stalled input stage lost its item")

endmodule

// File: tb/speech_segment_detector_tb.sv
// ----------------------------------------------------------------------------
// Speech segment detector testbench
// Drives probability frames and end-of-audio flushes into the detector. The
// frames come mostly as speech runs followed by silence runs, with some noise
// mixed in, under several threshold, length and padding settings. A
// behavioral model of the hysteresis, segment filter and padding predicts
// every padded segment, and each segment that leaves the block is checked
// field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speech_segment_detector_tb;
  import ssd_pkg::*;

  localparam int FRAME_SAMPLES  = 512;
  localparam int SAMPLE_RATE_HZ = 16000;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 240;
  localparam int RUN_LIMIT      = 600000;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;

  // Register copies used by the prediction.
  logic [PROB_W-1:0] on_thr_cfg;
  logic [MS_W-1:0]   min_speech_cfg;
  logic [MS_W-1:0]   min_silence_cfg;
  logic [MS_W-1:0]   pad_cfg;

  // Detector state as predicted.
  bit   in_speech;
  smp_t open_start;
  smp_t silence_start;
  smp_t frame_pos;
  bit   held_valid;
  smp_t held_start;
  smp_t held_end;

  in_item_t  items_to_send[$];
  out_item_t segments_due[$];
  out_item_t due_seg;

  int items_queued      = 0;
  int frames_queued     = 0;
  int items_accepted    = 0;
  int flushes_accepted  = 0;
  int segments_checked  = 0;
  int settings_applied  = 0;
  int mismatches        = 0;
  int cycle_count       = 0;
  int burst_left        = 1;
  int gap_left          = 0;
  int stall_tick        = 0;
  ready_mode_e ready_mode = RDY_ALWAYS;

  speech_segment_detector #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic smp_t ms_samples(input logic [MS_W-1:0] ms);
    logic [63:0] prod;
    prod = 64'(SAMPLE_RATE_HZ) * 64'(ms) / 64'(MS_PER_S);
    return prod[SMP_W-1:0];
  endfunction

  function automatic logic [PROB_W-1:0] off_level(input logic [PROB_W-1:0] on_thr);
    if (int'(on_thr) > int'(OFF_FLOOR) + int'(OFF_DELTA)) begin
      return on_thr - OFF_DELTA;
    end
    return OFF_FLOOR;
  endfunction

  task automatic clear_detector();
    in_speech     = 1'b0;
    open_start    = '0;
    silence_start = '0;
    frame_pos     = '0;
    held_valid    = 1'b0;
    held_start    = '0;
    held_end      = '0;
  endtask

  // A closed segment that passes the length filter becomes the held one; the
  // previously held segment leaves with its end padded toward the new start.
  task automatic keep_segment(input smp_t seg_start, input smp_t seg_end);
    smp_t      pad;
    smp_t      gap;
    smp_t      half;
    out_item_t seg;
    pad = ms_samples(pad_cfg);
    if (smp_t'(seg_end - seg_start) <= ms_samples(min_speech_cfg)) begin
      return;
    end
    if (!held_valid) begin
      held_start = (seg_start >= pad) ? seg_start - pad : '0;
    end else begin
      gap = seg_start - held_end;
      seg.segment_start = held_start;
      seg.final_segment = 1'b0;
      if (64'(gap) < 64'(pad) * 2) begin
        half = gap >> 1;
        seg.segment_end = held_end + half;
        held_start = seg_start - half;
      end else begin
        seg.segment_end = held_end + pad;
        held_start = (seg_start >= pad) ? seg_start - pad : '0;
      end
      segments_due.insert(segments_due.size(), seg);
    end
    held_end   = seg_end;
    held_valid = 1'b1;
  endtask

  task automatic advance_detector(input in_item_t item);
    smp_t              cur;
    logic [PROB_W-1:0] off;
    logic [SMP_W:0]    padded_end;
    out_item_t         seg;
    if (item.command == CMD_FRAME) begin
      cur = frame_pos;
      off = off_level(on_thr_cfg);
      frame_pos = frame_pos + smp_t'(FRAME_SAMPLES);
      if (item.probability >= on_thr_cfg && silence_start != 0) begin
        silence_start = '0;
      end
      if (item.probability >= on_thr_cfg && !in_speech) begin
        in_speech  = 1'b1;
        open_start = cur;
        return;
      end
      if (item.probability < off && in_speech) begin
        if (silence_start == 0) begin
          silence_start = cur;
        end
        if (smp_t'(cur - silence_start) < ms_samples(min_silence_cfg)) begin
          return;
        end
        keep_segment(open_start, silence_start);
        open_start    = '0;
        silence_start = '0;
        in_speech     = 1'b0;
      end
    end else begin
      if (in_speech) begin
        keep_segment(open_start, frame_pos);
      end
      if (held_valid) begin
        padded_end = {1'b0, held_end} + {1'b0, ms_samples(pad_cfg)};
        if (padded_end > {1'b0, item.audio_length}) begin
          padded_end = {1'b0, item.audio_length};
        end
        seg.segment_start = held_start;
        seg.segment_end   = padded_end[SMP_W-1:0];
        seg.final_segment = 1'b1;
        segments_due.insert(segments_due.size(), seg);
      end
      clear_detector();
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_detector(in_data_i);
        items_accepted++;
        if (in_data_i.command == CMD_FLUSH) begin
          flushes_accepted++;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= items_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each segment with the oldest prediction, and stalls
  // on a ready pattern that it picks at random among always, coin, sparse and mostly.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        segments_checked++;
        if (segments_due.size() == 0) begin
          $error("Unexpected segment: start %0d end %0d final %0d",
                 out_data_o.segment_start, out_data_o.segment_end,
                 out_data_o.final_segment);
          mismatches++;
        end else begin
          due_seg = segments_due.pop_front();
          if (out_data_o.segment_start !== due_seg.segment_start) begin
            $error("segment_start: expected %0d, actual %0d",
                   due_seg.segment_start, out_data_o.segment_start);
            mismatches++;
          end
          if (out_data_o.segment_end !== due_seg.segment_end) begin
            $error("segment_end: expected %0d, actual %0d",
                   due_seg.segment_end, out_data_o.segment_end);
            mismatches++;
          end
          if (out_data_o.final_segment !== due_seg.final_segment) begin
            $error("final_segment: expected %0d, actual %0d",
                   due_seg.final_segment, out_data_o.final_segment);
            mismatches++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 97 == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready_i <= (stall_tick % 5 == 0);
        default:    out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic push_frame(input logic [PROB_W-1:0] prob);
    in_item_t item;
    item.command      = CMD_FRAME;
    item.probability  = prob;
    item.audio_length = $urandom;
    items_to_send.insert(items_to_send.size(), item);
    items_queued++;
    frames_queued++;
  endtask

  task automatic push_flush(input smp_t total_samples);
    in_item_t item;
    item.command      = CMD_FLUSH;
    item.probability  = PROB_W'($urandom_range(0, 65535));
    item.audio_length = total_samples;
    items_to_send.insert(items_to_send.size(), item);
    items_queued++;
    frames_queued = 0;
  endtask

  // Audio lengths near the current position make the end clamp bite.
  function automatic smp_t pick_audio_length();
    smp_t len;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: begin
        len = smp_t'(frames_queued * FRAME_SAMPLES);
        len = len + $urandom_range(0, 4000) - 2000;
        return len;
      end
    endcase
  endfunction

  function automatic logic [PROB_W-1:0] speech_prob();
    return PROB_W'($urandom_range(65535, on_thr_cfg));
  endfunction

  function automatic logic [PROB_W-1:0] silence_prob();
    return PROB_W'($urandom_range(off_level(on_thr_cfg) - 1, 0));
  endfunction

  task automatic queue_traffic(input int n_items);
    int                target;
    int                sp_hint;
    int                sil_hint;
    int                run_len;
    int                choice;
    int                k;
    logic [PROB_W-1:0] off;
    target   = items_queued + n_items;
    off      = off_level(on_thr_cfg);
    sp_hint  = int'(ms_samples(min_speech_cfg) / FRAME_SAMPLES) + 4;
    sil_hint = int'(ms_samples(min_silence_cfg) / FRAME_SAMPLES) + 3;
    if (sp_hint > 40) begin
      sp_hint = 40;
    end
    if (sil_hint > 24) begin
      sil_hint = 24;
    end
    while (items_queued < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        run_len = $urandom_range(1, 6);
        for (k = 0; k < run_len; k++) begin
          push_frame(PROB_W'($urandom_range(0, 65535)));
        end
      end else if (choice < 15) begin
        push_flush(pick_audio_length());
      end else begin
        run_len = $urandom_range(1, sp_hint);
        for (k = 0; k < run_len; k++) begin
          if (off < on_thr_cfg && $urandom_range(0, 5) == 0) begin
            push_frame(PROB_W'($urandom_range(on_thr_cfg - 1, off)));
          end else begin
            push_frame(speech_prob());
          end
        end
        run_len = $urandom_range(1, sil_hint);
        for (k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            push_frame(speech_prob());
          end else begin
            push_frame(silence_prob());
          end
        end
      end
    end
  endtask

  // Waits until the sender is empty and every predicted segment has arrived,
  // then lets the pipeline settle for items that cause no segment.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid_i || segments_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_ON_THR:      on_thr_cfg      = value;
      REG_MIN_SPEECH:  min_speech_cfg  = value;
      REG_MIN_SILENCE: min_silence_cfg = value;
      default:         pad_cfg         = value;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] on_thr, input logic [CFG_W-1:0] speech_ms,
                           input logic [CFG_W-1:0] silence_ms, input logic [CFG_W-1:0] pad_ms);
    write_reg(REG_ON_THR, on_thr);
    write_reg(REG_MIN_SPEECH, speech_ms);
    write_reg(REG_MIN_SILENCE, silence_ms);
    write_reg(REG_PAD, pad_ms);
    settings_applied++;
    queue_traffic(PHASE_ITEMS);
    wait_idle();
  endtask

  initial begin
    on_thr_cfg      = RST_ON_THR;
    min_speech_cfg  = MS_W'(RST_MIN_SPEECH_MS);
    min_silence_cfg = MS_W'(RST_MIN_SILENCE_MS);
    pad_cfg         = MS_W'(RST_PAD_MS);
    clear_detector();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a flush with nothing held, a segment that opens exactly
    // at the threshold and just passes the length filter, frames right at the
    // off threshold and one below the on threshold, then a flush that emits
    // two segments with the last one clamped to the audio length.
    push_flush('0);
    push_frame(on_thr_cfg);
    repeat (6) push_frame('1);
    push_frame(off_level(on_thr_cfg));
    push_frame(PROB_W'(off_level(on_thr_cfg) - 1));
    repeat (4) push_frame('0);
    push_frame(PROB_W'(on_thr_cfg - 1));
    repeat (8) push_frame('1);
    push_flush(smp_t'(11500));
    wait_idle();

    queue_traffic(PHASE_ITEMS);
    wait_idle();
    settings_applied++;

    run_phase(16'hFFFF, '0, '0, '0);
    run_phase('0, '0, '0, 16'hFFFF);
    run_phase(16'd20000, 16'hFFFF, 16'hFFFF, '0);
    run_phase(16'd40000, 16'd50, 16'd20, 16'd100);
    run_phase(16'd10485, CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 300)),
              CFG_W'($urandom_range(0, 250)));
    run_phase(16'd10486, CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 300)),
              CFG_W'($urandom_range(0, 250)));
    run_phase(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 400)),
              CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 250)));
    run_phase(RST_ON_THR, CFG_W'(RST_MIN_SPEECH_MS), CFG_W'(RST_MIN_SILENCE_MS),
              CFG_W'(RST_PAD_MS));

    $display("Run covered %0d items, %0d of them end-of-audio flushes, under %0d settings.",
             items_accepted, flushes_accepted, settings_applied);
    $display("Compared %0d segments and found %0d mismatches.", segments_checked, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Timeout after %0d cycles with %0d segments outstanding.",
             cycle_count, segments_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_cfg.sv
rtl/ssd_core.sv
rtl/ssd_outq.sv
rtl/speech_segment_detector.sv
tb/speech_segment_detector_tb.sv
